### src/step_sequencer_note_lookup_top_defines.svh
// ----------------------------------------------------------------------------
// Step sequencer note lookup: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEP_SEQUENCER_NOTE_LOOKUP_TOP_DEFINES_SVH
`define STEP_SEQUENCER_NOTE_LOOKUP_TOP_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define SSNL_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define SSNL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### src/ssnl_pkg.sv
// ----------------------------------------------------------------------------
// Step sequencer note lookup: package
// Shared codes, field widths and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package ssnl_pkg;

  localparam int TIME_W  = 32;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 8;
  localparam int SINCE_W = 23;
  localparam int CFG_W   = 7;

  localparam logic [VALUE_W-1:0] HOLD_CODE = 8'hFF;
  localparam logic [VALUE_W-1:0] REST_CODE = 8'hFE;

  localparam logic [1:0] ST_NOTE  = 2'd0;
  localparam logic [1:0] ST_REST  = 2'd1;
  localparam logic [1:0] ST_HOLDS = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam logic CFG_SEQ_LENGTH = 1'b0;
  localparam logic CFG_STEPS_LOG2 = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_LOAD = 4'b0100,
    S_SRCH = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### src/ssnl_step_mem.sv
// ----------------------------------------------------------------------------
// Step sequencer note lookup: step table
// Single-port write, registered-read memory holding one value per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnl_step_mem
  import ssnl_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [VALUE_W-1:0] wr_data,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [VALUE_W-1:0] rd_data_r
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### src/ssnl_mod_unit.sv
// ----------------------------------------------------------------------------
// Step sequencer note lookup: remainder unit
// Restoring remainder, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnl_mod_unit
  import ssnl_pkg::*;
#(
  parameter int LW = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [LW-1:0]     divisor,
  output logic      [LW-1:0]     rem,
  output div_stat_t              stat
);

  localparam int CW = $clog2(TIME_W + 1);

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [LW-1:0]     rem_r, rem_nxt;
  logic [LW-1:0]     dvs_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [LW:0]       trial;
  logic [LW:0]       diff;

  assign trial = {rem_r, q_r[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = CW'(TIME_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt   = {q_r[TIME_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[LW-1:0] : trial[LW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign rem       = rem_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

### src/step_sequencer_note_lookup_top.sv
// ----------------------------------------------------------------------------
// Step sequencer note lookup: top level
// Step table with write and time-query items; a query finds the current step
// and searches backwards past hold entries for the note in effect.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                         Handshake
//  -------   --------------------------------------------  --------------------
//  input     in_mode in_step_index in_step_value           start & !busy
//            in_time_beats
//  result    out_status out_note out_since_note             out_strobe, 1 cycle
//            out_current_step
//  config    cfg_index cfg_wdata                            cfg_we
//
//  Timing: a write item is answered in the cycle after it is taken. A query
//  item passes through the remainder unit (one time bit per cycle), a
//  handover and the issue of the first read, then n table reads, one per
//  cycle through the single memory read port, where n (1 to len+1) is the
//  number of table reads; the result is then registered and shown.
//  Reset: synchronous, active low; clears control state and sets seq_length
//  to 16 and steps_per_beat_log2 to 2. The step table is not cleared.
//  Stalls: busy is high while a query is in flight; the receiver cannot stall,
//  so each result shows for one cycle only. A new item may be taken in the
//  cycle a result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "step_sequencer_note_lookup_top_defines.svh"

module step_sequencer_note_lookup_top
  import ssnl_pkg::*;
#(
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_mode,
  input  wire logic        [INDEX_W-1:0] in_step_index,
  input  wire logic signed [VALUE_W-1:0] in_step_value,
  input  wire logic        [TIME_W-1:0]  in_time_beats,
  output logic                           out_strobe,
  output logic             [1:0]         out_status,
  output logic signed      [VALUE_W-1:0] out_note,
  output logic             [SINCE_W-1:0] out_since_note,
  output logic             [INDEX_W-1:0] out_current_step,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic        [CFG_W-1:0]   cfg_wdata
);

  // Widths derived from the table depth and the fraction width.
  localparam int IW  = $clog2(MAX_STEPS);
  localparam int LW  = $clog2(MAX_STEPS + 1);
  localparam int XW  = (IW > INDEX_W) ? IW : INDEX_W;
  localparam int SHW = $clog2(FRAC_BITS + 1);
  localparam int SW  = LW + FRAC_BITS;
  localparam int WW  = (SW > SINCE_W) ? SW : SINCE_W;

  // Configuration registers.
  logic [CFG_W-1:0] seq_len_r;
  logic [2:0]       spb_log2_r;

  // Control and query context.
  state_t            state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [SHW-1:0]    shift_r, shift_nxt;
  logic [TIME_W-1:0] t_r;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     addr_r, addr_nxt;
  logic [LW-1:0]     search_r, search_nxt;

  // Result registers.
  logic               strobe_r, strobe_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [VALUE_W-1:0] note_r, note_nxt;
  logic [SINCE_W-1:0] since_r, since_nxt;
  logic [INDEX_W-1:0] step_r, step_nxt;

  logic               accept;
  logic               qry_acc;
  logic               wr_acc;
  logic [XW-1:0]      idx_ext;
  logic               idx_ok;
  logic [LW-1:0]      len_calc;
  logic [SHW-1:0]     shift_calc;
  logic [TIME_W-1:0]  q_in;
  logic [IW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [LW-1:0]      div_rem;
  div_stat_t          div_stat;
  logic               srch_end;
  logic [TIME_W-1:0]  off_mask;
  logic [WW-1:0]      since_wide;
  logic [XW-1:0]      cur_ext;

  // Step back one entry, wrapping to the end of the active sequence.
  function automatic logic [IW-1:0] step_back(input logic [IW-1:0] pos,
                                              input logic [LW-1:0] len);
    logic [LW-1:0] last;
    last = len - LW'(1);
    return (pos == '0) ? last[IW-1:0] : pos - IW'(1);
  endfunction

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign qry_acc = accept && in_mode;
  assign wr_acc  = accept && !in_mode;

  // Write address: drop writes beyond the table.
  assign idx_ext = XW'(in_step_index);
  assign idx_ok  = (32'(in_step_index) < 32'(MAX_STEPS));

  // Clamp the sequence length into 1..MAX_STEPS.
  always_comb begin
    if (seq_len_r == '0) begin
      len_calc = LW'(1);
    end else if (32'(seq_len_r) > 32'(MAX_STEPS)) begin
      len_calc = LW'(MAX_STEPS);
    end else begin
      len_calc = LW'(seq_len_r);
    end
  end

  // Step length is 2^shift raw units; a rate finer than the fraction saturates.
  assign shift_calc = (32'(spb_log2_r) < 32'(FRAC_BITS))
                    ? (SHW'(FRAC_BITS) - SHW'(spb_log2_r)) : '0;
  assign q_in = in_time_beats >> shift_calc;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r  <= CFG_W'(16);
      spb_log2_r <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEQ_LENGTH: seq_len_r  <= cfg_wdata;
        CFG_STEPS_LOG2: spb_log2_r <= cfg_wdata[2:0];
      endcase
    end
  end

  ssnl_mod_unit #(
    .LW (LW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (qry_acc),
    .dividend (q_in),
    .divisor  (len_calc),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // Issue the current step first, then walk back one entry per cycle.
  assign rd_addr = (state_r == S_LOAD) ? cur_r : addr_r;

  ssnl_step_mem #(
    .DEPTH (MAX_STEPS),
    .AW    (IW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_acc && idx_ok),
    .wr_addr   (idx_ext[IW-1:0]),
    .wr_data   (in_step_value),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Stop on the first non-hold entry or after len+1 reads.
  assign srch_end = (rd_data != HOLD_CODE) || (search_r >= len_r);

  // Time since the step that ended the search: whole steps plus in-step offset.
  assign off_mask   = ~({TIME_W{1'b1}} << shift_r);
  assign since_wide = (WW'(search_r) << shift_r) | WW'(t_r & off_mask);
  assign cur_ext    = XW'(cur_r);

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    shift_nxt  = shift_r;
    cur_nxt    = cur_r;
    addr_nxt   = addr_r;
    search_nxt = search_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    note_nxt   = note_r;
    since_nxt  = since_r;
    step_nxt   = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (wr_acc) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_WRITE;
          note_nxt   = '0;
          since_nxt  = '0;
          step_nxt   = '0;
        end else if (qry_acc) begin
          len_nxt   = len_calc;
          shift_nxt = shift_calc;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          cur_nxt   = div_rem[IW-1:0];
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        addr_nxt   = step_back(cur_r, len_r);
        search_nxt = '0;
        state_nxt  = S_SRCH;
      end
      S_SRCH: begin
        if (srch_end) begin
          strobe_nxt = 1'b1;
          step_nxt   = cur_ext[INDEX_W-1:0];
          note_nxt   = rd_data;
          if (rd_data == REST_CODE) begin
            status_nxt = ST_REST;
            since_nxt  = '0;
          end else begin
            status_nxt = (rd_data == HOLD_CODE) ? ST_HOLDS : ST_NOTE;
            since_nxt  = since_wide[SINCE_W-1:0];
          end
          state_nxt = S_IDLE;
        end else begin
          // Hold entry: advance to the previous step.
          search_nxt = search_r + LW'(1);
          addr_nxt   = step_back(addr_r, len_r);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    shift_r  <= shift_nxt;
    cur_r    <= cur_nxt;
    addr_r   <= addr_nxt;
    search_r <= search_nxt;
    status_r <= status_nxt;
    note_r   <= note_nxt;
    since_r  <= since_nxt;
    step_r   <= step_nxt;
    if (qry_acc) begin
      t_r <= in_time_beats;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_note         = $signed(note_r);
  assign out_since_note   = since_r;
  assign out_current_step = step_r;

  // Results only show once the block has gone back to idle.
  `SSNL_ASSERT_SAME(a_strobe_idle, out_strobe, !busy, "result shown while busy")
  // The remainder unit runs only while a query waits on it.
  `SSNL_ASSERT_SAME(a_div_owner, div_stat.busy || div_stat.done, state_r == S_DIV,
                    "remainder unit active outside its state")
  // A query item enters the remainder phase.
  `SSNL_ASSERT_NEXT(a_query_start, qry_acc, state_r == S_DIV, "query not started")
  // The search never runs past len+1 reads.
  `SSNL_ASSERT_SAME(a_search_bound, state_r == S_SRCH, search_r <= len_r,
                    "search overran the sequence")
  // A write item is answered in the very next cycle.
  `SSNL_ASSERT_NEXT(a_write_answer, wr_acc, out_strobe && out_status == ST_WRITE,
                    "write item not answered")

endmodule

`default_nettype wire
